[rtl/vee_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vee_pkg
// Types, type codes and the per-format encode functions of the element encoder.
// ----------------------------------------------------------------------------
package vee_pkg;

    localparam logic [2:0] TYPE_F32  = 3'd0;
    localparam logic [2:0] TYPE_F16  = 3'd1;
    localparam logic [2:0] TYPE_BF16 = 3'd2;
    localparam logic [2:0] TYPE_I8   = 3'd3;
    localparam logic [2:0] TYPE_U8   = 3'd4;
    localparam logic [2:0] TYPE_BIT  = 3'd5;

    typedef struct packed {
        logic [31:0] element_bits;
        logic        last_element;
    } vee_in_t;

    typedef struct packed {
        logic [31:0] code;
        logic [2:0]  code_bytes;
        logic        end_of_vector;
    } vee_out_t;

    // Half-precision encode with the rounding rules of the block.
    function automatic logic [15:0] enc_f16(input logic [31:0] x);
        logic        s;
        logic [7:0]  e8;
        logic [22:0] m;
        logic [23:0] full;
        logic [4:0]  sh;
        logic [15:0] h;
        logic [12:0] rem;
        logic [23:0] sub;
        logic        rbit;
        s = x[31];
        e8 = x[30:23];
        m = x[22:0];
        full = {1'b1, m};
        sh = 5'd0;
        sub = 24'd0;
        rbit = 1'b0;
        rem = m[12:0];
        h = 16'd0;
        if (e8 == 8'hff) begin
            h = {s, 5'h1f, (m != 23'd0), 9'd0};
        end else if (e8 >= 8'd143) begin
            h = {s, 15'h7c00};
        end else if (e8 <= 8'd112) begin
            if (e8 < 8'd102) begin
                h = {s, 15'd0};
            end else begin
                // e = e8-112 in [-10,0]; shift = 14-e = 126-e8
                sh = 5'(8'd126 - e8);
                sub = full >> sh;
                rbit = full[5'(sh - 5'd1)];
                h = {s, 15'(sub[14:0] + {14'd0, rbit})};
            end
        end else begin
            h = {s, 5'(e8 - 8'd112), m[22:13]};
            if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) begin
                h = h + 16'd1;
            end
        end
        return h;
    endfunction

    function automatic logic [15:0] enc_bf16(input logic [31:0] x);
        logic [31:0] t;
        if (x[30:23] == 8'hff && x[22:0] != 23'd0) begin
            return x[31:16] | 16'h0040;
        end
        t = x + {31'd0, x[16]} + 32'h7fff;
        return t[31:16];
    endfunction

    // Round half away from zero and saturate; is_u selects the U8 range.
    function automatic logic [7:0] enc_int(input logic [31:0] x, input logic is_u);
        logic [7:0]  e8;
        logic [23:0] full;
        logic [4:0]  sh;
        logic [24:0] r;
        logic [8:0]  mag;
        logic        neg;
        logic [7:0]  res;
        e8 = x[30:23];
        neg = x[31];
        full = {1'b1, x[22:0]};
        sh = 5'd0;
        r = 25'd0;
        mag = 9'd0;
        if (e8 == 8'hff && x[22:0] != 23'd0) begin
            mag = 9'd0;
        end else if (e8 < 8'd126) begin
            mag = 9'd0;
        end else if (e8 >= 8'd135) begin
            mag = 9'h1ff;
        end else begin
            sh = 5'(8'd150 - e8);
            r = ({1'b0, full} + (25'd1 << (sh - 5'd1))) >> sh;
            mag = r[8:0];
        end
        if (is_u) begin
            if (neg) res = 8'd0;
            else if (mag > 9'd255) res = 8'd255;
            else res = mag[7:0];
        end else begin
            if (neg) res = (mag >= 9'd128) ? 8'h80 : 8'(9'd0 - mag);
            else res = (mag > 9'd127) ? 8'd127 : mag[7:0];
        end
        return res;
    endfunction

endpackage

[rtl/vee_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vee_core
// Combinational encoder: selects the format and updates the bit packer state.
// ----------------------------------------------------------------------------
module vee_core import vee_pkg::*; (
    input  logic [2:0] element_type,
    input  vee_in_t    in_item,
    input  logic [7:0] acc,
    input  logic [2:0] pos,
    output vee_out_t   out_item,
    output logic       out_has,
    output logic [7:0] acc_new,
    output logic [2:0] pos_new
);
    logic [31:0] x;
    logic        flag;
    logic [7:0]  acc_or;

    assign x = in_item.element_bits;
    assign flag = !x[31] && x[30:0] != 31'd0 && x[30:0] <= 31'h7f800000;
    assign acc_or = acc | ({7'd0, flag} << pos);

    always_comb begin
        out_item = '0;
        out_item.end_of_vector = in_item.last_element;
        out_has = 1'b1;
        acc_new = acc;
        pos_new = pos;
        case (element_type)
            TYPE_F32: begin
                out_item.code = x;
                out_item.code_bytes = 3'd4;
            end
            TYPE_F16: begin
                out_item.code = {16'd0, enc_f16(x)};
                out_item.code_bytes = 3'd2;
            end
            TYPE_BF16: begin
                out_item.code = {16'd0, enc_bf16(x)};
                out_item.code_bytes = 3'd2;
            end
            TYPE_I8: begin
                out_item.code = {24'd0, enc_int(x, 1'b0)};
                out_item.code_bytes = 3'd1;
            end
            TYPE_U8: begin
                out_item.code = {24'd0, enc_int(x, 1'b1)};
                out_item.code_bytes = 3'd1;
            end
            TYPE_BIT: begin
                out_item.code = {24'd0, acc_or};
                out_item.code_bytes = 3'd1;
                if (pos == 3'd7 || in_item.last_element) begin
                    acc_new = 8'd0;
                    pos_new = 3'd0;
                end else begin
                    acc_new = acc_or;
                    pos_new = pos + 3'd1;
                    out_has = 1'b0;
                end
            end
            default: begin
                out_has = 1'b0;
            end
        endcase
    end
endmodule

[rtl/vector_element_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_element_encoder_top
// Encodes single-precision elements into f32, f16, bf16, i8, u8 or packed bits.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the s_ channel (valid/ready) carrying one element and a
// last-element flag. Encoded requests leave on the m_ channel with the code,
// its byte count and an end-of-vector flag. The element type register is
// written through cfg_we/cfg_data while the block is idle; the user keeps to
// this, the block does not enforce it. A write also restarts the bit packer
// on a byte boundary. An accepted request is presented at m_ in the following
// cycle. Throughput is one request per cycle without receiver stalls, set by
// the single result register; the encode logic sits between the input
// handshake and it. When the receiver stalls, the result register holds and
// s_ready drops while a result is held and m_ready is low, whether or not the
// next request would produce a result. A request with no result (bit mode
// mid-byte, unused type codes) is accepted; bit mode updates the packer.
// Reset clears the type to f32, empties the packer and the result register.
// ----------------------------------------------------------------------------
module vector_element_encoder_top import vee_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  vee_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output vee_out_t   m_data
);
    logic [2:0] type_reg;
    logic [7:0] acc_reg, acc_next;
    logic [2:0] pos_reg, pos_next;
    logic       valid_reg;
    vee_out_t   data_reg, data_next;
    logic       has;
    logic       accept;

    vee_core u_core (
        .element_type (type_reg),
        .in_item      (s_data),
        .acc          (acc_reg),
        .pos          (pos_reg),
        .out_item     (data_next),
        .out_has      (has),
        .acc_new      (acc_next),
        .pos_new      (pos_next)
    );

    // The output register frees up in the same cycle it is taken.
    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_reg  <= TYPE_F32;
            acc_reg   <= 8'd0;
            pos_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                type_reg <= cfg_data;
                acc_reg  <= 8'd0;
                pos_reg  <= 3'd0;
            end else if (accept) begin
                acc_reg <= acc_next;
                pos_reg <= pos_next;
            end
            if (accept) begin
                valid_reg <= has;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && has) begin
            data_reg <= data_next;
        end
    end
endmodule

[rtl/vee_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vee_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module vee_checker import vee_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input vee_out_t m_data
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed under stall");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    a_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.code_bytes == 3'd1 || m_data.code_bytes == 3'd2
                     || m_data.code_bytes == 3'd4))
        else $error("bad byte count");

    a_no_spawn: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !(s_valid && s_ready) |=> !m_valid)
        else $error("result without request");
endmodule

bind vector_element_encoder_top vee_checker u_vee_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/tb_vector_element_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_element_encoder_top
// Self-checking bench for the element encoder: directed corner elements in every
// type setting and random elements in every format, compared against an encoder model.
// ----------------------------------------------------------------------------

class vee_scoreboard;
    vee_pkg::vee_out_t pending_codes[$];
    logic [2:0]        elem_type;
    logic [7:0]        flag_byte;
    logic [2:0]        flag_pos;
    int                errors;

    function new();
        elem_type = vee_pkg::TYPE_F32;
        flag_byte = 8'd0;
        flag_pos  = 3'd0;
        errors    = 0;
    endfunction

    // A type write also restarts the bit packer.
    function void set_type(logic [2:0] t);
        elem_type = t;
        flag_byte = 8'd0;
        flag_pos  = 3'd0;
    endfunction

    function logic [15:0] half_of(logic [31:0] x);
        logic [15:0] sgn;
        int          ex;
        logic [31:0] mant;
        logic [31:0] h;
        logic [31:0] rem;
        int          sh;
        sgn  = {x[31], 15'd0};
        ex   = int'(x[30:23]);
        mant = {9'd0, x[22:0]};
        if (ex == 255) return sgn | 16'h7c00 | ((mant != 0) ? 16'h0200 : 16'h0);
        ex = ex - 112;
        if (ex >= 31) return sgn | 16'h7c00;
        if (ex <= 0) begin
            if (ex < -10) return sgn;
            mant = mant | 32'h800000;
            sh   = 14 - ex;
            h    = (mant >> sh) + ((mant >> (sh - 1)) & 32'd1);
            return sgn | h[15:0];
        end
        h   = {16'd0, sgn} | (ex << 10) | (mant >> 13);
        rem = mant & 32'h1fff;
        if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h = h + 1;
        return h[15:0];
    endfunction

    function logic [15:0] brain_of(logic [31:0] x);
        logic [31:0] t;
        if (x[30:23] == 8'hff && x[22:0] != 0) return x[31:16] | 16'h0040;
        t = x + {31'd0, x[16]} + 32'h7fff;
        return t[31:16];
    endfunction

    function logic [7:0] int_of(logic [31:0] x, int lo, int hi);
        int          ex;
        int          v;
        logic [31:0] full;
        int          sh;
        ex = int'(x[30:23]);
        if (ex == 255 && x[22:0] != 0) return 8'd0;
        if (ex < 126) v = 0;
        else if (ex >= 135) v = x[31] ? -100000 : 100000;
        else begin
            full = {9'd1, x[22:0]};
            sh   = 150 - ex;
            v    = int'((full + (32'd1 << (sh - 1))) >> sh);
            if (x[31]) v = -v;
        end
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v[7:0];
    endfunction

    // Note an accepted request and queue the code it produces, if any.
    function void note_request(vee_pkg::vee_in_t req);
        vee_pkg::vee_out_t r;
        logic [31:0] x;
        x = req.element_bits;
        r.end_of_vector = req.last_element;
        case (elem_type)
            vee_pkg::TYPE_F32: begin r.code = x; r.code_bytes = 3'd4; end
            vee_pkg::TYPE_F16: begin r.code = {16'd0, half_of(x)}; r.code_bytes = 3'd2; end
            vee_pkg::TYPE_BF16: begin r.code = {16'd0, brain_of(x)}; r.code_bytes = 3'd2; end
            vee_pkg::TYPE_I8: begin r.code = {24'd0, int_of(x, -128, 127)}; r.code_bytes = 3'd1; end
            vee_pkg::TYPE_U8: begin r.code = {24'd0, int_of(x, 0, 255)}; r.code_bytes = 3'd1; end
            vee_pkg::TYPE_BIT: begin
                if (!x[31] && x[30:0] != 0 && x[30:0] <= 31'h7f800000)
                    flag_byte[flag_pos] = 1'b1;
                if (flag_pos == 3'd7 || req.last_element) begin
                    r.code = {24'd0, flag_byte};
                    r.code_bytes = 3'd1;
                    flag_byte = 8'd0;
                    flag_pos = 3'd0;
                end else begin
                    flag_pos = flag_pos + 3'd1;
                    return;
                end
            end
            default: return;
        endcase
        pending_codes.push_back(r);
    endfunction

    function void check_code(vee_pkg::vee_out_t got);
        vee_pkg::vee_out_t e;
        if (pending_codes.size() == 0) begin
            $error("unexpected code %h", got.code);
            errors++;
            return;
        end
        e = pending_codes.pop_front();
        if (got.code !== e.code) begin
            $error("code: expected %h, got %h", e.code, got.code);
            errors++;
        end
        if (got.code_bytes !== e.code_bytes) begin
            $error("code_bytes: expected %0d, got %0d", e.code_bytes, got.code_bytes);
            errors++;
        end
        if (got.end_of_vector !== e.end_of_vector) begin
            $error("end_of_vector: expected %b, got %b", e.end_of_vector, got.end_of_vector);
            errors++;
        end
    endfunction
endclass

module tb_vector_element_encoder_top;
    import vee_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     cfg_we = 1'b0;
    logic [2:0] cfg_data = 3'd0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    vee_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    vee_out_t m_data;

    vee_scoreboard codes_sb = new();

    // When set, the receiver stops idling; the sender checks it too.
    bit quiet_phase = 1'b0;
    // Set by the sender to request one long receiver hold-off.
    bit hold_request = 1'b0;

    always #5 aclk = ~aclk;

    vector_element_encoder_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Results are checked on the edge where they are accepted.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) codes_sb.check_code(m_data);
    end

    // Receiver: random stall bursts, a long hold-off on request, none at the end.
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Offers one request and waits until it is taken; the model is fed on acceptance.
    task automatic send_element(input logic [31:0] bits, input logic last);
        vee_in_t req;
        int n;
        if (!quiet_phase && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 9);
            repeat (n) @(posedge aclk);
        end
        req.element_bits = bits;
        req.last_element = last;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        codes_sb.note_request(req);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (codes_sb.pending_codes.size() != 0) @(posedge aclk);
        // A request with no result may still be in flight.
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_type(input logic [2:0] t);
        cfg_we   <= 1'b1;
        cfg_data <= t;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        codes_sb.set_type(t);
    endtask

    // Random single with a bias toward the interesting exponent ranges.
    function automatic logic [31:0] pick_element();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 7))
            0: x[30:23] = 8'(100 + $urandom_range(0, 16));   // around the f16 subnormal range
            1: x[30:23] = 8'(124 + $urandom_range(0, 13));   // integer range
            2: x[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
            3: x[12:0]  = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
            4: x[15:0]  = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            default: ;
        endcase
        return x;
    endfunction

    initial begin
        logic [31:0] corner[$] = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
            32'h7fc00001, 32'hff800001, 32'h00000001, 32'h807fffff, 32'h3f000000,
            32'hbf000000, 32'h3fc00000, 32'h42fe0000, 32'h43000000, 32'hc3010000,
            32'h437f0000, 32'h477ff000, 32'h33000000, 32'h33800001, 32'h38800000,
            32'h3f801000, 32'h3f803000, 32'h3f808000, 32'h7f7fffff, 32'hffffffff};
        logic [2:0] order[$] = '{TYPE_F32, TYPE_F16, TYPE_BF16, TYPE_I8, TYPE_U8, TYPE_BIT,
            3'd6, 3'd7};
        int k;
        logic [2:0] t;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: the corners in every type setting, reset type first.
        foreach (order[i]) begin
            if (i != 0) write_type(order[i]);
            foreach (corner[j]) send_element(corner[j], j == corner.size() - 1);
            drain_results();
        end

        // Random phases; the first one fills the block under a long stall.
        for (int phase = 0; phase < 12; phase++) begin
            t = (phase < 6) ? 3'(phase) : 3'($urandom_range(0, 7));
            if (phase == 10) t = TYPE_BIT;
            if (phase == 11) begin
                t = TYPE_F16;
                quiet_phase = 1'b1;
            end
            write_type(t);
            if (phase == 0) hold_request = 1'b1;
            k = $urandom_range(15, 27);
            for (int i = 0; i < k; i++)
                send_element(pick_element(),
                    (t == TYPE_BIT) ? ($urandom_range(0, 10) == 0)
                                    : 1'($urandom_range(0, 1)));
            drain_results();
        end

        if (codes_sb.errors == 0) begin
            $display("tb_vector_element_encoder_top: done, clean");
        end else begin
            $display("tb_vector_element_encoder_top: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_vector_element_encoder_top: done, errors");
        $finish;
    end
endmodule
